FILE: rtl/core/tksi_pkg.sv
// ----------------------------------------------------------------------------
// tksi_pkg
// Shared types, widths and codes for the top-k sorted insertion store.
// ----------------------------------------------------------------------------
package tksi_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int SCORE_W     = 32;
	localparam int TAG_W       = 64;
	localparam int RANK_W      = 4;
	localparam int TOL_W       = 16;
	localparam int CORNERS     = 6;

	localparam logic [SCORE_W-1:0] EMPTY_SCORE = '1;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_READ   = 1'b1
	} command_t;

	typedef enum logic [1:0] {
		ST_INSERTED   = 2'd0,
		ST_DUPLICATE  = 2'd1,
		ST_NOT_BETTER = 2'd2,
		ST_READ_DATA  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_UPDATE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic compare;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		command_t                    command;
		logic [SCORE_W-1:0]          score;
		logic [4:0]                  type_code;
		logic [7:0]                  start_offset;
		logic [2:0]                  vertex_count;
		logic [CORNERS-1:0][7:0]     corner;
		logic [RANK_W-1:0]           read_rank;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [RANK_W-1:0]  rank;
		logic [SCORE_W-1:0] threshold_score;
		logic [SCORE_W-1:0] entry_score;
		logic [TAG_W-1:0]   entry_tag;
	} result_t;

endpackage

FILE: rtl/core/tksi_ifs.sv
// ----------------------------------------------------------------------------
// tksi channel interfaces
// Valid/ready channels for candidates, results and the tolerance register.
// ----------------------------------------------------------------------------
interface tksi_item_if import tksi_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               command;
	logic [SCORE_W-1:0] score;
	logic [4:0]         type_code;
	logic [7:0]         start_offset;
	logic [2:0]         vertex_count;
	logic [7:0]         corner_0;
	logic [7:0]         corner_1;
	logic [7:0]         corner_2;
	logic [7:0]         corner_3;
	logic [7:0]         corner_4;
	logic [7:0]         corner_5;
	logic [RANK_W-1:0]  read_rank;

	modport source (
		output valid, command, score, type_code, start_offset, vertex_count,
		       corner_0, corner_1, corner_2, corner_3, corner_4, corner_5, read_rank,
		input  ready
	);
	modport sink (
		input  valid, command, score, type_code, start_offset, vertex_count,
		       corner_0, corner_1, corner_2, corner_3, corner_4, corner_5, read_rank,
		output ready
	);
endinterface

interface tksi_result_if import tksi_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [RANK_W-1:0]  rank;
	logic [SCORE_W-1:0] threshold_score;
	logic [SCORE_W-1:0] entry_score;
	logic [TAG_W-1:0]   entry_tag;

	modport source (
		output valid, status, rank, threshold_score, entry_score, entry_tag,
		input  ready
	);
	modport sink (
		input  valid, status, rank, threshold_score, entry_score, entry_tag,
		output ready
	);
endinterface

interface tksi_cfg_if import tksi_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [TOL_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: rtl/core/tksi_ctrl.sv
// ----------------------------------------------------------------------------
// tksi_ctrl
// Sequencer: capture, compare against all ranks, then update and load result.
// ----------------------------------------------------------------------------
module tksi_ctrl import tksi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_COMPARE;
				end
			end
			S_COMPARE: begin
				cmd.compare = 1'b1;
				state_d     = S_UPDATE;
			end
			S_UPDATE: begin
				// result register must be free, or emptying this cycle
				if (!out_valid_q || out_ready) begin
					cmd.update = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/tksi_datapath.sv
// ----------------------------------------------------------------------------
// tksi_datapath
// Ranked score/tag registers, per-rank comparators and the result register.
// ----------------------------------------------------------------------------
module tksi_datapath import tksi_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  item_t            item,
	input  logic             tol_we,
	input  logic [TOL_W-1:0] tol_data,
	output result_t          result
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	function automatic logic [TAG_W-1:0] pack_tag(input item_t it);
		logic [TAG_W-1:0] t;
		t        = '0;
		t[63:59] = it.type_code;
		t[58:51] = it.start_offset;
		t[50:48] = it.vertex_count;
		for (int h = 0; h < CORNERS; h++) begin
			if (3'(h) < it.vertex_count) begin
				t[8*h +: 8] = it.corner[h];
			end
		end
		return t;
	endfunction

	logic [TOL_W-1:0]   tol_q;
	logic [SCORE_W-1:0] score_q [ENTRIES];
	logic [TAG_W-1:0]   tag_q   [ENTRIES];
	logic [SCORE_W-1:0] score_nx [ENTRIES];
	logic [TAG_W-1:0]   tag_nx   [ENTRIES];

	command_t           command_s1;
	logic [SCORE_W-1:0] score_s1;
	logic [TAG_W-1:0]   tag_s1;
	logic [RANK_W-1:0]  read_rank_s1;

	logic [ENTRIES-1:0] lt_c, dup_c;
	logic [ENTRIES-1:0] lt_s2, dup_s2;

	logic               do_ins;
	logic [IDX_W-1:0]   pos;
	logic [SCORE_W-1:0] rd_score;
	logic [TAG_W-1:0]   rd_tag;
	result_t            res_d, res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= '0;
		end else if (tol_we) begin
			tol_q <= tol_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			command_s1   <= item.command;
			score_s1     <= item.score;
			tag_s1       <= pack_tag(item);
			read_rank_s1 <= item.read_rank;
		end
	end

	// Ranks stay sorted ascending with empties (all ones) at the tail, so lt is a
	// thermometer: the insert point is its lowest set bit.
	for (genvar g = 0; g < ENTRIES; g++) begin : g_ent
		logic [SCORE_W-1:0] diff;
		assign diff     = (score_s1 >= score_q[g]) ? (score_s1 - score_q[g])
		                                           : (score_q[g] - score_s1);
		assign lt_c[g]  = score_s1 < score_q[g];
		assign dup_c[g] = (score_q[g] != EMPTY_SCORE) && (diff <= SCORE_W'(tol_q));

		if (g == 0) begin : g_head
			assign score_nx[g] = (do_ins && lt_s2[g]) ? score_s1 : score_q[g];
			assign tag_nx[g]   = (do_ins && lt_s2[g]) ? tag_s1   : tag_q[g];
		end else begin : g_body
			assign score_nx[g] = (do_ins && lt_s2[g])
			                   ? (lt_s2[g-1] ? score_q[g-1] : score_s1) : score_q[g];
			assign tag_nx[g]   = (do_ins && lt_s2[g])
			                   ? (lt_s2[g-1] ? tag_q[g-1] : tag_s1) : tag_q[g];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			lt_s2  <= lt_c;
			dup_s2 <= dup_c;
		end
	end

	assign do_ins = cmd.update && (command_s1 == CMD_INSERT) && !(|dup_s2) && (|lt_s2);

	always_comb begin
		pos = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (lt_s2[i]) begin
				pos = IDX_W'(i);
			end
		end
	end

	always_comb begin
		rd_score = EMPTY_SCORE;
		rd_tag   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (i < (1 << RANK_W) && read_rank_s1 == RANK_W'(i)) begin
				rd_score = score_q[i];
				rd_tag   = tag_q[i];
			end
		end
	end

	always_comb begin
		res_d                 = '0;
		res_d.threshold_score = score_nx[ENTRIES-1];
		if (command_s1 == CMD_READ) begin
			res_d.status      = ST_READ_DATA;
			res_d.rank        = read_rank_s1;
			res_d.entry_score = rd_score;
			res_d.entry_tag   = rd_tag;
		end else if (|dup_s2) begin
			res_d.status = ST_DUPLICATE;
		end else if (!(|lt_s2)) begin
			res_d.status = ST_NOT_BETTER;
		end else begin
			res_d.status = ST_INSERTED;
			res_d.rank   = RANK_W'(pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				score_q[i] <= EMPTY_SCORE;
				tag_q[i]   <= '0;
			end
		end else if (do_ins) begin
			for (int i = 0; i < ENTRIES; i++) begin
				score_q[i] <= score_nx[i];
				tag_q[i]   <= tag_nx[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

FILE: rtl/core/top_k_sorted_insert.sv
// ----------------------------------------------------------------------------
// top_k_sorted_insert
// Keeps the ENTRIES lowest scores with their tags, ranked ascending.
// ----------------------------------------------------------------------------
// Usage
//   cand : request channel. command insert offers score plus tag fields;
//          command read returns the entry at read_rank.
//   res  : one result per request: status, rank, worst kept score after the
//          request, and for a read the entry's score and packed tag.
//   cfg  : writes dup_tolerance; always ready. Write only while idle.
// Timing
//   A request is captured, compared against every rank in parallel in the
//   next cycle, and applied in the update step once the result register is
//   free; the result becomes valid when the update loads it. One request at
//   a time: the next waits until the capture/compare/update sequence ends.
//   cand is ready again as soon as the result is loaded, even if it is still
//   waiting on res; a stalled res holds its result and the next request waits
//   in the update step until the result register frees.
// Reset
//   All ranks empty (all ones), tags zero, tolerance zero, no result pending.
// ----------------------------------------------------------------------------
module top_k_sorted_insert import tksi_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	tksi_cfg_if.sink     cfg,
	tksi_item_if.sink    cand,
	tksi_result_if.source res
);

	dp_cmd_t cmd;
	item_t   item;
	result_t result;

	assign cfg.ready = 1'b1;

	assign item.command      = command_t'(cand.command);
	assign item.score        = cand.score;
	assign item.type_code    = cand.type_code;
	assign item.start_offset = cand.start_offset;
	assign item.vertex_count = cand.vertex_count;
	assign item.corner       = {cand.corner_5, cand.corner_4, cand.corner_3,
	                            cand.corner_2, cand.corner_1, cand.corner_0};
	assign item.read_rank    = cand.read_rank;

	tksi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cand.valid),
		.in_ready  (cand.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd)
	);

	tksi_datapath #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item     (item),
		.tol_we   (cfg.valid),
		.tol_data (cfg.data),
		.result   (result)
	);

	assign res.status          = result.status;
	assign res.rank            = result.rank;
	assign res.threshold_score = result.threshold_score;
	assign res.entry_score     = result.entry_score;
	assign res.entry_tag       = result.entry_tag;

endmodule

FILE: rtl/core/tksi_checker.sv
// ----------------------------------------------------------------------------
// tksi_assertions
// Port-level checks on the sorted insertion store, bound to the top level.
// ----------------------------------------------------------------------------
module tksi_assertions import tksi_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cand_valid,
	input logic               cand_ready,
	input logic               res_valid,
	input logic               res_ready,
	input logic [1:0]         res_status,
	input logic [RANK_W-1:0]  res_rank,
	input logic [SCORE_W-1:0] res_threshold,
	input logic [SCORE_W-1:0] res_entry_score,
	input logic [TAG_W-1:0]   res_entry_tag
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_rank)
			&& $stable(res_threshold) && $stable(res_entry_score) && $stable(res_entry_tag))
		else $error("result changed while stalled");

	// one request in flight: busy the cycle after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cand_valid && cand_ready |=> !cand_ready)
		else $error("request accepted while previous one in progress");

	// entry fields are only filled for reads
	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_status != ST_READ_DATA |-> res_entry_score == '0
			&& res_entry_tag == '0)
		else $error("entry fields set on an insert result");

	// rejected inserts report rank zero
	a_reject_rank: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status == ST_DUPLICATE || res_status == ST_NOT_BETTER)
			|-> res_rank == '0)
		else $error("rank set on a rejected insert");

endmodule

bind top_k_sorted_insert tksi_assertions u_tksi_assertions (
	.clk             (clk),
	.arst_n          (arst_n),
	.cand_valid      (cand.valid),
	.cand_ready      (cand.ready),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.res_status      (res.status),
	.res_rank        (res.rank),
	.res_threshold   (res.threshold_score),
	.res_entry_score (res.entry_score),
	.res_entry_tag   (res.entry_tag)
);
